FILE: rtl/core/assert_macros.svh
// assertion shorthands, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

FILE: rtl/core/bsra_pkg.sv
package bsra_pkg;

  // field widths of the stream beats
  localparam int BADDR_W    = 10;
  localparam int BYTE_W     = 8;
  localparam int RUN_W      = 12;
  localparam int SECTOR_W   = 18;
  localparam int STATUS_W   = 2;
  localparam int FIRST_W    = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // apb port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register word index, taken from paddr[2]
  localparam logic REG_FIRST_SECTOR = 1'b0;

  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_OK          = 2'd0;
  localparam status_t STAT_NO_FREE     = 2'd1;
  localparam status_t STAT_ALREADY_SET = 2'd2;
  localparam status_t STAT_PAST_END    = 2'd3;

endpackage

FILE: rtl/core/bsra_ram.sv
module bsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bitmap_sector_run_allocator_top.sv
// channel   role    handshake           payload
// s_*       input   s_tvalid/s_tready   s_tdata: byte_addr, byte_value, run_length; s_tuser: func
// m_*       output  m_tvalid/m_tready   m_tdata: start_sector, status
// apb       config  psel/penable/pready pwdata: first_sector at word 0
//
// a load beat is done in S_IDLE; an allocate beat scans from byte 0 up to the first bitmap byte
// that is not full, then walks the bytes the run touches
// the bitmap RAM read port walks one byte per cycle, first scanning, then setting run bits
// after rst a clearing pass writes zero to every bitmap byte,
// with s_tready low; apb writes are taken meanwhile
// a new beat is taken while the last result still waits in the output register

`include "assert_macros.svh"

module bitmap_sector_run_allocator_top #(
  parameter int BITMAP_BYTES = 1024,
  parameter int MAX_RUN      = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [9:0] byte_addr, [17:10] byte_value, [29:18] run_length, [31:30] zero
  input  logic [bsra_pkg::IN_DATA_W-1:0]      s_tdata,
  // [0] func
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [17:0] start_sector, [19:18] status, [23:20] zero
  output logic [bsra_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bsra_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bsra_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bsra_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import bsra_pkg::*;

  localparam int ADDR_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(BITMAP_BYTES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  // input fields
  logic               func;
  logic [BADDR_W-1:0] byte_addr;
  logic [BYTE_W-1:0]  byte_value;
  logic [RUN_W-1:0]   run_length;
  logic [RUN_W-1:0]   run_sat;
  logic               load_in_range;

  assign func       = s_tuser[0];
  assign byte_addr  = s_tdata[9:0];
  assign byte_value = s_tdata[17:10];
  assign run_length = s_tdata[29:18];

  assign run_sat = (32'(run_length) > MAX_RUN) ? RUN_W'(MAX_RUN) : run_length;
  assign load_in_range = (32'(byte_addr) < BITMAP_BYTES);

  // registers
  logic [2:0]          state, state_next;
  logic [ADDR_W-1:0]   clr, clr_next;
  logic [ADDR_W-1:0]   chk, chk_next;
  logic [ADDR_W-1:0]   cur, cur_next;
  logic [2:0]          bit_pos, bit_pos_next;
  logic [RUN_W-1:0]    left, left_next;
  logic                first, first_next;
  logic [BYTE_W-1:0]   hold, hold_next;
  logic [SECTOR_W-1:0] start, start_next;
  logic [SECTOR_W-1:0] res_start;
  status_t             res_status;
  logic [SECTOR_W-1:0] out_start;
  status_t             out_status;
  logic [FIRST_W-1:0]  first_sector;

  // bitmap ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] rd_data;

  bsra_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // lowest clear bit of the scanned byte
  logic [2:0] free_bit;

  always_comb begin
    free_bit = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!rd_data[i]) begin
        free_bit = 3'(i);
      end
    end
  end

  // bits of the current byte covered by the rest of the run
  logic [BYTE_W-1:0] walk_v;
  logic [3:0]        room;
  logic [3:0]        span;
  logic [3:0]        span_end;
  logic [BYTE_W-1:0] run_mask;
  logic [BYTE_W-1:0] conflict;
  logic [BYTE_W-1:0] below;
  logic [RUN_W-1:0]  left_rem;

  assign walk_v   = first ? hold : rd_data;
  assign room     = 4'd8 - {1'b0, bit_pos};
  assign span     = (left < RUN_W'(room)) ? left[3:0] : room;
  assign span_end = {1'b0, bit_pos} + span;
  assign conflict = walk_v & run_mask;
  assign below    = (conflict - 8'd1) & ~conflict;
  assign left_rem = left - RUN_W'(span);

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      run_mask[i] = (4'(i) >= {1'b0, bit_pos}) && (4'(i) < span_end);
    end
  end

  // finished result and output slot
  logic                fin;
  logic [SECTOR_W-1:0] fin_start;
  status_t             fin_status;
  logic                slot_free;
  logic                out_load;

  assign slot_free = !m_tvalid || m_tready;
  assign out_load  = slot_free && (fin || (state == S_RESP));

  // sequencer: clear, take beat, scan bytes, walk run
  always_comb begin
    state_next   = state;
    clr_next     = clr;
    chk_next     = chk;
    cur_next     = cur;
    bit_pos_next = bit_pos;
    left_next    = left;
    first_next   = first;
    hold_next    = hold;
    start_next   = start;
    ram_we       = 1'b0;
    ram_waddr    = clr;
    ram_wdata    = '0;
    ram_raddr    = chk + 1'b1;
    fin          = 1'b0;
    fin_start    = '0;
    fin_status   = STAT_OK;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == LAST_BYTE) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = '0;
        if (s_tvalid) begin
          if (func) begin
            fin = 1'b1;
            if (load_in_range) begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(byte_addr);
              ram_wdata = byte_value;
            end else begin
              fin_status = STAT_PAST_END;
            end
          end else if (run_sat == '0) begin
            fin = 1'b1;
          end else begin
            left_next  = run_sat;
            chk_next   = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_data != FULL_BYTE) begin
          state_next   = S_WALK;
          first_next   = 1'b1;
          hold_next    = rd_data;
          cur_next     = chk;
          bit_pos_next = free_bit;
          start_next   = SECTOR_W'({chk, free_bit}) + SECTOR_W'(first_sector) - 1'b1;
        end else if (chk == LAST_BYTE) begin
          fin        = 1'b1;
          fin_start  = '1;
          fin_status = STAT_NO_FREE;
        end else begin
          chk_next = chk + 1'b1;
        end
      end
      S_WALK: begin
        ram_raddr  = cur + 1'b1;
        ram_we     = 1'b1;
        ram_waddr  = cur;
        first_next = 1'b0;
        fin_start  = start;
        if (conflict != '0) begin
          ram_wdata  = walk_v | (run_mask & below);
          fin        = 1'b1;
          fin_status = STAT_ALREADY_SET;
        end else begin
          ram_wdata = walk_v | run_mask;
          left_next = left_rem;
          if (left_rem == '0) begin
            fin = 1'b1;
          end else if (cur == LAST_BYTE) begin
            fin        = 1'b1;
            fin_status = STAT_PAST_END;
          end else begin
            cur_next     = cur + 1'b1;
            bit_pos_next = 3'd0;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // park the result when the output register is still full
    if (fin) begin
      state_next = slot_free ? S_IDLE : S_RESP;
    end
  end

  assign s_tready = (state == S_IDLE);

  // control and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk     <= chk_next;
    cur     <= cur_next;
    bit_pos <= bit_pos_next;
    left    <= left_next;
    first   <= first_next;
    hold    <= hold_next;
    start   <= start_next;
    if (fin && !slot_free) begin
      res_start  <= fin_start;
      res_status <= fin_status;
    end
    if (out_load) begin
      out_start  <= fin ? fin_start : res_start;
      out_status <= fin ? fin_status : res_status;
    end
  end

  assign m_tdata = {4'b0, out_status, out_start};

  // apb register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sector <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FIRST_SECTOR)) begin
      first_sector <= pwdata[FIRST_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIRST_SECTOR) ? APB_DATA_W'(first_sector) : '0;

  // checks
  `ASSERT_ALWAYS(a_walk_only_sets, (state == S_WALK) |-> ((ram_wdata & walk_v) == walk_v))
  `ASSERT_ALWAYS(a_walk_has_work, (state == S_WALK) |-> (left != '0))
  `ASSERT_ALWAYS(a_resp_output_busy, (state == S_RESP) |-> m_tvalid)
  `ASSERT_NEVER(a_no_free_start, m_tvalid && (out_status == STAT_NO_FREE) && (out_start != '1))

endmodule
